>>> sv/forth_source_lexer_core_macros.svh
// Assertion macros shared by the lexer checker.
// Each macro expects clk and rst_n to be visible in the scope of use.
`ifndef FORTH_SOURCE_LEXER_CORE_MACROS_SVH
`define FORTH_SOURCE_LEXER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSL_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FSL_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/fsl_pkg.sv
`default_nettype none

package fsl_pkg;

    // Result event codes.
    localparam logic [1:0] EV_TEXT      = 2'd0;
    localparam logic [1:0] EV_TOKEN_END = 2'd1;
    localparam logic [1:0] EV_EOS       = 2'd2;
    localparam logic [1:0] EV_ERROR     = 2'd3;

    // Token kinds reported at token end.
    localparam logic [1:0] KIND_WORD     = 2'd0;
    localparam logic [1:0] KIND_STRING   = 2'd1;
    localparam logic [1:0] KIND_UNSIGNED = 2'd2;
    localparam logic [1:0] KIND_NEGATIVE = 2'd3;

    // Error codes.
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_BAD_STRING   = 3'd1;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd2;
    localparam logic [2:0] ERR_EMPTY_WORD   = 3'd3;
    localparam logic [2:0] ERR_NULL_BYTE    = 3'd4;

    // Input modes.
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_EOS  = 1'b1;

    // Radix codes.
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_BIN = 2'd1;
    localparam logic [1:0] RADIX_OCT = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_A_LOWER   = 8'h61;
    localparam logic [7:0] CH_B_LOWER   = 8'h62;
    localparam logic [7:0] CH_F_LOWER   = 8'h66;
    localparam logic [7:0] CH_O_LOWER   = 8'h6F;
    localparam logic [7:0] CH_X_LOWER   = 8'h78;
    localparam logic [7:0] CH_TILDE     = 8'h7E;

    // Digit value that marks a byte outside the digit set.
    localparam logic [4:0] DIGIT_NONE = 5'd16;

    // Per-entry record that the back end expands into results; the number value travels beside it.
    typedef struct packed {
        logic [1:0] ev1;
        logic [1:0] kind1;
        logic [7:0] byte1;
        logic [2:0] err1;
        logic       two;
        logic [1:0] ev2;
    } res_rec_t;

    // Value of a byte in the digit set "0123456789abcdef".
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [7:0] diff;
        begin
            diff = 8'h00;
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                diff = c - CH_ZERO;
                digit_of = diff[4:0];
            end
            else if (c >= CH_A_LOWER && c <= CH_F_LOWER)
            begin
                diff = c - CH_A_LOWER + 8'd10;
                digit_of = diff[4:0];
            end
            else
            begin
                digit_of = DIGIT_NONE;
            end
        end
    endfunction

    // Numeric base of a radix code.
    function automatic logic [4:0] radix_value(input logic [1:0] code);
        begin
            case (code)
                RADIX_DEC: radix_value = 5'd10;
                RADIX_BIN: radix_value = 5'd2;
                RADIX_OCT: radix_value = 5'd8;
                RADIX_HEX: radix_value = 5'd16;
                default:   radix_value = 5'd10;
            endcase
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/fsl_front.sv
`default_nettype none

module fsl_front #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     src_valid,
    output logic                          src_stall,
    input  wire logic                     mode,
    input  wire logic [7:0]               in_byte,
    input  wire logic                     q_full,
    output logic                          q_push,
    output fsl_pkg::res_rec_t             q_rec,
    output logic [VALUE_BITS-1:0]         q_val
);

    typedef enum logic [2:0] {
        LX_BETWEEN,
        LX_WORD,
        LX_STRING,
        LX_COMMENT,
        LX_ERROR
    } lex_state_t;

    lex_state_t              state_reg, state_next;
    logic [2:0]              err_code_reg, err_code_next;
    logic                    sign_reg, sign_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic [1:0]              radix_reg, radix_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic                    numeric_reg, numeric_next;
    logic                    lzero_reg, lzero_next;

    logic                    accept;
    logic                    is_space;
    logic                    is_print;
    logic                    starting;
    logic [1:0]              b_cnt;
    logic [1:0]              b_radix;
    logic [VALUE_BITS-1:0]   b_acc;
    logic                    b_numeric;
    logic                    b_lzero;
    logic [4:0]              digit;
    logic [4:0]              base;
    logic                    is_prefix;
    logic [VALUE_BITS-1:0]   scaled;
    logic [1:0]              nc_radix;
    logic                    nc_numeric;
    logic [VALUE_BITS-1:0]   nc_acc;
    logic                    nc_lzero;
    logic [1:0]              nc_cnt;
    logic                    we_numeric;
    logic [1:0]              we_kind;
    logic [VALUE_BITS-1:0]   we_val;

    // The queue is the only thing that holds the source back.
    assign src_stall = q_full;
    assign accept    = src_valid && !q_full;

    // Byte classes.
    assign is_space = (in_byte == fsl_pkg::CH_SPACE)
        || (in_byte >= fsl_pkg::CH_TAB && in_byte <= fsl_pkg::CH_CR);
    assign is_print = (in_byte >= fsl_pkg::CH_SPACE) && (in_byte <= fsl_pkg::CH_TILDE);

    // A new word starts from a cleared number state.
    assign starting  = (state_reg == LX_BETWEEN);
    assign b_cnt     = starting ? 2'd0 : cnt_reg;
    assign b_radix   = starting ? fsl_pkg::RADIX_DEC : radix_reg;
    assign b_acc     = starting ? '0 : acc_reg;
    assign b_numeric = starting ? 1'b1 : numeric_reg;
    assign b_lzero   = starting ? 1'b0 : lzero_reg;

    assign digit = fsl_pkg::digit_of(in_byte);
    assign base  = fsl_pkg::radix_value(b_radix);

    // A b, o or x right after a leading zero selects the radix.
    assign is_prefix = (b_cnt == 2'd1) && b_lzero
        && ((in_byte == fsl_pkg::CH_B_LOWER) || (in_byte == fsl_pkg::CH_O_LOWER)
            || (in_byte == fsl_pkg::CH_X_LOWER));

    // Accumulator times the radix, built from shifts.
    always_comb
    begin
        case (b_radix)
            fsl_pkg::RADIX_DEC: scaled = (b_acc << 3) + (b_acc << 1);
            fsl_pkg::RADIX_BIN: scaled = b_acc << 1;
            fsl_pkg::RADIX_OCT: scaled = b_acc << 3;
            fsl_pkg::RADIX_HEX: scaled = b_acc << 4;
            default:            scaled = b_acc;
        endcase
    end

    // Number state after one more word character.
    always_comb
    begin
        nc_radix   = b_radix;
        nc_numeric = b_numeric;
        nc_acc     = b_acc;
        if (is_prefix)
        begin
            if (in_byte == fsl_pkg::CH_B_LOWER)
            begin
                nc_radix = fsl_pkg::RADIX_BIN;
            end
            else if (in_byte == fsl_pkg::CH_O_LOWER)
            begin
                nc_radix = fsl_pkg::RADIX_OCT;
            end
            else
            begin
                nc_radix = fsl_pkg::RADIX_HEX;
            end
        end
        else if (b_numeric)
        begin
            if (digit >= base)
            begin
                nc_numeric = 1'b0;
            end
            else
            begin
                nc_acc = scaled + {{(VALUE_BITS-4){1'b0}}, digit[3:0]};
            end
        end
        nc_lzero = b_lzero || ((b_cnt == 2'd0) && (in_byte == fsl_pkg::CH_ZERO));
        nc_cnt   = (b_cnt == 2'd3) ? 2'd3 : b_cnt + 2'd1;
    end

    // Kind and value of the word in progress, if it ends now.
    assign we_numeric = numeric_reg && !(sign_reg && (cnt_reg == 2'd0));
    assign we_kind    = we_numeric
        ? (sign_reg ? fsl_pkg::KIND_NEGATIVE : fsl_pkg::KIND_UNSIGNED)
        : fsl_pkg::KIND_WORD;
    assign we_val     = we_numeric ? acc_reg : '0;

    // Lexer step for one accepted item.
    always_comb
    begin
        state_next    = state_reg;
        err_code_next = err_code_reg;
        sign_next     = sign_reg;
        cnt_next      = cnt_reg;
        radix_next    = radix_reg;
        acc_next      = acc_reg;
        numeric_next  = numeric_reg;
        lzero_next    = lzero_reg;
        q_push        = 1'b0;
        q_rec         = '0;
        q_val         = '0;
        if (accept)
        begin
            if (state_reg == LX_ERROR)
            begin
                q_push     = 1'b1;
                q_rec.ev1  = fsl_pkg::EV_ERROR;
                q_rec.err1 = err_code_reg;
            end
            else if (mode == fsl_pkg::MODE_EOS)
            begin
                q_push = 1'b1;
                if (state_reg == LX_STRING)
                begin
                    q_rec.ev1     = fsl_pkg::EV_ERROR;
                    q_rec.err1    = fsl_pkg::ERR_UNTERMINATED;
                    state_next    = LX_ERROR;
                    err_code_next = fsl_pkg::ERR_UNTERMINATED;
                end
                else if (state_reg == LX_WORD)
                begin
                    q_rec.ev1   = fsl_pkg::EV_TOKEN_END;
                    q_rec.kind1 = we_kind;
                    q_rec.two   = 1'b1;
                    q_rec.ev2   = fsl_pkg::EV_EOS;
                    q_val       = we_val;
                    state_next  = LX_BETWEEN;
                end
                else
                begin
                    q_rec.ev1  = fsl_pkg::EV_EOS;
                    state_next = LX_BETWEEN;
                end
            end
            else if (in_byte == fsl_pkg::CH_NUL)
            begin
                q_push        = 1'b1;
                q_rec.ev1     = fsl_pkg::EV_ERROR;
                q_rec.err1    = fsl_pkg::ERR_NULL_BYTE;
                state_next    = LX_ERROR;
                err_code_next = fsl_pkg::ERR_NULL_BYTE;
            end
            else
            begin
                case (state_reg)
                    LX_BETWEEN:
                    begin
                        if (is_space)
                        begin
                            state_next = LX_BETWEEN;
                        end
                        else if (in_byte == fsl_pkg::CH_BACKSLASH)
                        begin
                            state_next = LX_COMMENT;
                        end
                        else if (in_byte == fsl_pkg::CH_QUOTE)
                        begin
                            state_next = LX_STRING;
                        end
                        else if (in_byte == fsl_pkg::CH_HASH)
                        begin
                            q_push        = 1'b1;
                            q_rec.ev1     = fsl_pkg::EV_ERROR;
                            q_rec.err1    = fsl_pkg::ERR_EMPTY_WORD;
                            state_next    = LX_ERROR;
                            err_code_next = fsl_pkg::ERR_EMPTY_WORD;
                        end
                        else
                        begin
                            q_push      = 1'b1;
                            q_rec.ev1   = fsl_pkg::EV_TEXT;
                            q_rec.byte1 = in_byte;
                            state_next  = LX_WORD;
                            if (in_byte == fsl_pkg::CH_MINUS)
                            begin
                                sign_next    = 1'b1;
                                cnt_next     = b_cnt;
                                radix_next   = b_radix;
                                acc_next     = b_acc;
                                numeric_next = b_numeric;
                                lzero_next   = b_lzero;
                            end
                            else
                            begin
                                sign_next    = 1'b0;
                                cnt_next     = nc_cnt;
                                radix_next   = nc_radix;
                                acc_next     = nc_acc;
                                numeric_next = nc_numeric;
                                lzero_next   = nc_lzero;
                            end
                        end
                    end
                    LX_WORD:
                    begin
                        if (is_space || (in_byte == fsl_pkg::CH_QUOTE)
                            || (in_byte == fsl_pkg::CH_HASH))
                        begin
                            q_push      = 1'b1;
                            q_rec.ev1   = fsl_pkg::EV_TOKEN_END;
                            q_rec.kind1 = we_kind;
                            q_val       = we_val;
                            if (in_byte == fsl_pkg::CH_HASH)
                            begin
                                q_rec.two     = 1'b1;
                                q_rec.ev2     = fsl_pkg::EV_ERROR;
                                state_next    = LX_ERROR;
                                err_code_next = fsl_pkg::ERR_EMPTY_WORD;
                            end
                            else if (in_byte == fsl_pkg::CH_QUOTE)
                            begin
                                state_next = LX_STRING;
                            end
                            else
                            begin
                                state_next = LX_BETWEEN;
                            end
                        end
                        else
                        begin
                            q_push       = 1'b1;
                            q_rec.ev1    = fsl_pkg::EV_TEXT;
                            q_rec.byte1  = in_byte;
                            cnt_next     = nc_cnt;
                            radix_next   = nc_radix;
                            acc_next     = nc_acc;
                            numeric_next = nc_numeric;
                            lzero_next   = nc_lzero;
                        end
                    end
                    LX_STRING:
                    begin
                        q_push = 1'b1;
                        if (in_byte == fsl_pkg::CH_QUOTE)
                        begin
                            q_rec.ev1   = fsl_pkg::EV_TOKEN_END;
                            q_rec.kind1 = fsl_pkg::KIND_STRING;
                            state_next  = LX_BETWEEN;
                        end
                        else if (is_print)
                        begin
                            q_rec.ev1   = fsl_pkg::EV_TEXT;
                            q_rec.byte1 = in_byte;
                        end
                        else
                        begin
                            q_rec.ev1     = fsl_pkg::EV_ERROR;
                            q_rec.err1    = fsl_pkg::ERR_BAD_STRING;
                            state_next    = LX_ERROR;
                            err_code_next = fsl_pkg::ERR_BAD_STRING;
                        end
                    end
                    LX_COMMENT:
                    begin
                        if (in_byte == fsl_pkg::CH_NEWLINE)
                        begin
                            state_next = LX_BETWEEN;
                        end
                    end
                    default:
                    begin
                        state_next = state_reg;
                    end
                endcase
            end
        end
    end

    // Lexer state and number state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= LX_BETWEEN;
            err_code_reg <= fsl_pkg::ERR_NONE;
            sign_reg     <= 1'b0;
            cnt_reg      <= 2'd0;
            radix_reg    <= fsl_pkg::RADIX_DEC;
            acc_reg      <= '0;
            numeric_reg  <= 1'b1;
            lzero_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            err_code_reg <= err_code_next;
            sign_reg     <= sign_next;
            cnt_reg      <= cnt_next;
            radix_reg    <= radix_next;
            acc_reg      <= acc_next;
            numeric_reg  <= numeric_next;
            lzero_reg    <= lzero_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/fsl_queue.sv
`default_nettype none

module fsl_queue #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire fsl_pkg::res_rec_t        push_rec,
    input  wire logic [VALUE_BITS-1:0]    push_val,
    output logic                          full,
    output logic                          head_valid,
    output fsl_pkg::res_rec_t             head_rec,
    output logic [VALUE_BITS-1:0]         head_val,
    input  wire logic                     pop
);

    localparam int DEPTH   = 4;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = PTR_W + 1;

    fsl_pkg::res_rec_t       rec_mem [DEPTH];
    logic [VALUE_BITS-1:0]   val_mem [DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic                    do_push;
    logic                    do_pop;

    assign full       = (count_reg == COUNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = rec_mem[rd_ptr_reg];
    assign head_val   = val_mem[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            rec_mem[wr_ptr_reg] <= push_rec;
            val_mem[wr_ptr_reg] <= push_val;
        end
    end

endmodule

`default_nettype wire

>>> sv/fsl_back.sv
`default_nettype none

module fsl_back #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     head_valid,
    input  wire fsl_pkg::res_rec_t        head_rec,
    input  wire logic [VALUE_BITS-1:0]    head_val,
    output logic                          pop,
    output logic                          res_valid,
    input  wire logic                     res_stall,
    output logic [1:0]                    event_res,
    output logic [1:0]                    token_kind,
    output logic [7:0]                    text_byte,
    output logic [VALUE_BITS-1:0]         number_value,
    output logic [2:0]                    error_code,
    output logic                          last
);

    logic                    res_valid_reg;
    logic                    phase_reg;
    logic [1:0]              event_reg;
    logic [1:0]              kind_reg;
    logic [7:0]              byte_reg;
    logic [VALUE_BITS-1:0]   value_reg;
    logic [2:0]              err_reg;
    logic                    last_reg;
    logic                    load;

    // The output register takes a new result when empty or being drained.
    assign load = !res_valid_reg || !res_stall;
    assign pop  = load && head_valid && (phase_reg || !head_rec.two);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else if (load)
        begin
            res_valid_reg <= head_valid;
            if (head_valid)
            begin
                phase_reg <= !phase_reg && head_rec.two;
            end
        end
    end

    // Result payload: first result of an entry, or its trailing event.
    always_ff @(posedge clk)
    begin
        if (load && head_valid)
        begin
            if (!phase_reg)
            begin
                event_reg <= head_rec.ev1;
                kind_reg  <= head_rec.kind1;
                byte_reg  <= head_rec.byte1;
                value_reg <= head_val;
                err_reg   <= head_rec.err1;
                last_reg  <= !head_rec.two;
            end
            else
            begin
                event_reg <= head_rec.ev2;
                kind_reg  <= fsl_pkg::KIND_WORD;
                byte_reg  <= 8'h00;
                value_reg <= '0;
                err_reg   <= (head_rec.ev2 == fsl_pkg::EV_ERROR)
                    ? fsl_pkg::ERR_EMPTY_WORD : fsl_pkg::ERR_NONE;
                last_reg  <= 1'b1;
            end
        end
    end

    assign res_valid    = res_valid_reg;
    assign event_res    = event_reg;
    assign token_kind   = kind_reg;
    assign text_byte    = byte_reg;
    assign number_value = value_reg;
    assign error_code   = err_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

>>> sv/forth_source_lexer_core.sv
// Streaming lexer for Forth-like source text.
// Source channel: src_valid / src_stall carry one item per transfer, either a
// source byte (mode 0, in_byte) or the end-of-source mark (mode 1).
// Result channel: res_valid / res_stall carry one result per transfer: a text
// byte, a token end with kind and number value, end of source, or an error.
// An item causes zero, one or two results; last marks the final one.
// Each item's results pass through the queue and then the output register.
// Throughput: one source item per cycle while src_stall is low; the result side
// moves one result per cycle while res_stall is low, so an item with two results takes two transfers.
// The lexer front end handles each byte combinationally, including the
// radix multiply-add of the number accumulator, and hands result entries to a
// four-entry queue; the back end expands entries into the output register.
// When the receiver stalls, the result holds and the queue fills; src_stall
// rises only when the queue is full.
// Reset clears the lexer to between tokens, empties the queue and drops any
// pending result. Errors are sticky until reset; end of source otherwise
// returns the lexer to between tokens for a new source.
`default_nettype none

module forth_source_lexer_core #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     src_valid,
    output logic                          src_stall,
    input  wire logic                     mode,
    input  wire logic [7:0]               in_byte,
    output logic                          res_valid,
    input  wire logic                     res_stall,
    output logic [1:0]                    event_res,
    output logic [1:0]                    token_kind,
    output logic [7:0]                    text_byte,
    output logic [VALUE_BITS-1:0]         number_value,
    output logic [2:0]                    error_code,
    output logic                          last
);

    logic                    q_push;
    fsl_pkg::res_rec_t       q_rec;
    logic [VALUE_BITS-1:0]   q_val;
    logic                    q_full;
    logic                    q_head_valid;
    fsl_pkg::res_rec_t       q_head_rec;
    logic [VALUE_BITS-1:0]   q_head_val;
    logic                    q_pop;

    // Lexer front end.
    fsl_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .mode     (mode),
        .in_byte  (in_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_rec    (q_rec),
        .q_val    (q_val)
    );

    // Result entry queue.
    fsl_queue #(
        .VALUE_BITS(VALUE_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_rec  (q_rec),
        .push_val  (q_val),
        .full      (q_full),
        .head_valid(q_head_valid),
        .head_rec  (q_head_rec),
        .head_val  (q_head_val),
        .pop       (q_pop)
    );

    // Result back end.
    fsl_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_head_valid),
        .head_rec    (q_head_rec),
        .head_val    (q_head_val),
        .pop         (q_pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .event_res   (event_res),
        .token_kind  (token_kind),
        .text_byte   (text_byte),
        .number_value(number_value),
        .error_code  (error_code),
        .last        (last)
    );

endmodule

`default_nettype wire

>>> sv/fsl_checker.sv
`default_nettype none

`include "forth_source_lexer_core_macros.svh"

module fsl_checker #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     res_valid,
    input  wire logic                     res_stall,
    input  wire logic [1:0]               event_res,
    input  wire logic [2:0]               error_code,
    input  wire logic [VALUE_BITS-1:0]    number_value,
    input  wire logic                     last
);

    logic       err_seen_reg;
    logic [2:0] err_code_reg;
    logic       res_xfer;

    assign res_xfer = res_valid && !res_stall;

    // Remember the first error that left the block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_seen_reg <= 1'b0;
            err_code_reg <= fsl_pkg::ERR_NONE;
        end
        else if (res_xfer && (event_res == fsl_pkg::EV_ERROR) && !err_seen_reg)
        begin
            err_seen_reg <= 1'b1;
            err_code_reg <= error_code;
        end
    end

    // A stalled result stays offered.
    `FSL_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid, "result dropped while stalled")

    // After an error, every result repeats it with the same code.
    `FSL_ASSERT_IMP(a_sticky_error, res_valid && err_seen_reg, (event_res == fsl_pkg::EV_ERROR) && (error_code == err_code_reg), "error not sticky")

    // Only a token end can be followed by another result of the same item.
    `FSL_ASSERT_IMP(a_last_rule, res_valid && (event_res != fsl_pkg::EV_TOKEN_END), last, "non-final result is not a token end")

    // Error codes and number values appear only with their own events.
    `FSL_ASSERT_IMP(a_field_zero, res_valid && (event_res != fsl_pkg::EV_ERROR), (error_code == fsl_pkg::ERR_NONE) && ((event_res == fsl_pkg::EV_TOKEN_END) || (number_value == '0)), "stray error code or value")

endmodule

bind forth_source_lexer_core fsl_checker #(
    .VALUE_BITS(VALUE_BITS)
) u_fsl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .event_res   (event_res),
    .error_code  (error_code),
    .number_value(number_value),
    .last        (last)
);

`default_nettype wire

>>> verif/forth_source_lexer_checker.sv
module forth_source_lexer_checker #(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  src_valid,
    input  wire logic                  src_stall,
    input  wire logic                  mode,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  res_valid,
    input  wire logic                  res_stall,
    input  wire logic [1:0]            event_res,
    input  wire logic [1:0]            token_kind,
    input  wire logic [7:0]            text_byte,
    input  wire logic [VALUE_BITS-1:0] number_value,
    input  wire logic [2:0]            error_code,
    input  wire logic                  last,
    output int                         fail_count,
    output int                         pending_results
);

    import fsl_pkg::*;

    typedef enum logic [2:0] {
        LX_IDLE,
        LX_WORD,
        LX_STRING,
        LX_COMMENT,
        LX_FAULT
    } lex_state_t;

    typedef struct {
        logic [1:0]            ev;
        logic [1:0]            kind;
        logic [7:0]            chr;
        logic [VALUE_BITS-1:0] value;
        logic [2:0]            err;
        logic                  fin;
    } lex_result_t;

    // Shadow copy of the lexer state.
    lex_state_t            lex_state;
    logic [2:0]            fault_code;
    logic                  neg_seen;
    logic [1:0]            digits_seen;
    logic [1:0]            base_code;
    logic [VALUE_BITS-1:0] magnitude;
    logic                  numeric;
    logic                  zero_lead;

    // Results of the current byte, then the ordered store of results still due.
    lex_result_t step_res [2];
    int          step_n;
    lex_result_t token_results [$];
    int          mismatches;

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic int digit_weight(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            return int'(c) - int'(CH_ZERO);
        end
        if (c >= CH_A_LOWER && c <= CH_F_LOWER)
        begin
            return int'(c) - int'(CH_A_LOWER) + 10;
        end
        return 16;
    endfunction

    function automatic int base_of(input logic [1:0] code);
        case (code)
            RADIX_BIN: return 2;
            RADIX_OCT: return 8;
            RADIX_HEX: return 16;
            default:   return 10;
        endcase
    endfunction

    task automatic add_result(input logic [1:0] ev, input logic [1:0] kind,
                              input logic [7:0] chr, input logic [VALUE_BITS-1:0] value,
                              input logic [2:0] err);
        step_res[step_n].ev    = ev;
        step_res[step_n].kind  = kind;
        step_res[step_n].chr   = chr;
        step_res[step_n].value = value;
        step_res[step_n].err   = err;
        step_res[step_n].fin   = 1'b0;
        step_n++;
    endtask

    task automatic clear_number();
        neg_seen    = 1'b0;
        digits_seen = 2'd0;
        base_code   = RADIX_DEC;
        magnitude   = '0;
        numeric     = 1'b1;
        zero_lead   = 1'b0;
    endtask

    task automatic raise_fault(input logic [2:0] code);
        lex_state  = LX_FAULT;
        fault_code = code;
        add_result(EV_ERROR, KIND_WORD, 8'h00, '0, code);
    endtask

    // Fold one word byte into the number being read: radix prefix or digit.
    task automatic fold_digit(input logic [7:0] c);
        int                    d;
        logic [VALUE_BITS-1:0] bv;
        logic [VALUE_BITS-1:0] dv;
        bv = VALUE_BITS'(base_of(base_code));
        if (digits_seen == 2'd1 && zero_lead
            && (c == CH_B_LOWER || c == CH_O_LOWER || c == CH_X_LOWER))
        begin
            base_code = (c == CH_B_LOWER) ? RADIX_BIN
                      : (c == CH_O_LOWER) ? RADIX_OCT : RADIX_HEX;
        end
        else if (numeric)
        begin
            d = digit_weight(c);
            if (d >= base_of(base_code))
            begin
                numeric = 1'b0;
            end
            else
            begin
                dv = VALUE_BITS'(d);
                magnitude = magnitude * bv + dv;
            end
        end
        if (digits_seen == 2'd0 && c == CH_ZERO)
        begin
            zero_lead = 1'b1;
        end
        if (digits_seen != 2'd3)
        begin
            digits_seen = digits_seen + 2'd1;
        end
    endtask

    // A lone minus stays a word; anything else still numeric is a number.
    task automatic close_word();
        if (numeric && !(neg_seen && digits_seen == 2'd0))
        begin
            add_result(EV_TOKEN_END, neg_seen ? KIND_NEGATIVE : KIND_UNSIGNED, 8'h00,
                       magnitude, ERR_NONE);
        end
        else
        begin
            add_result(EV_TOKEN_END, KIND_WORD, 8'h00, '0, ERR_NONE);
        end
        clear_number();
    endtask

    // Advance the shadow lexer by one source item and queue what it yields.
    task automatic lex_item(input logic m, input logic [7:0] c);
        step_n = 0;
        if (lex_state == LX_FAULT)
        begin
            raise_fault(fault_code);
        end
        else if (m == MODE_EOS)
        begin
            if (lex_state == LX_STRING)
            begin
                raise_fault(ERR_UNTERMINATED);
            end
            else
            begin
                if (lex_state == LX_WORD)
                begin
                    close_word();
                end
                add_result(EV_EOS, KIND_WORD, 8'h00, '0, ERR_NONE);
                lex_state = LX_IDLE;
                clear_number();
            end
        end
        else if (c == CH_NUL)
        begin
            raise_fault(ERR_NULL_BYTE);
        end
        else
        begin
            case (lex_state)
                LX_IDLE:
                begin
                    if (is_blank(c))
                    begin
                    end
                    else if (c == CH_BACKSLASH)
                    begin
                        lex_state = LX_COMMENT;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        lex_state = LX_STRING;
                    end
                    else if (c == CH_HASH)
                    begin
                        raise_fault(ERR_EMPTY_WORD);
                    end
                    else
                    begin
                        lex_state = LX_WORD;
                        clear_number();
                        if (c == CH_MINUS)
                        begin
                            neg_seen = 1'b1;
                        end
                        else
                        begin
                            fold_digit(c);
                        end
                        add_result(EV_TEXT, KIND_WORD, c, '0, ERR_NONE);
                    end
                end
                LX_WORD:
                begin
                    if (is_blank(c))
                    begin
                        close_word();
                        lex_state = LX_IDLE;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        close_word();
                        lex_state = LX_STRING;
                    end
                    else if (c == CH_HASH)
                    begin
                        close_word();
                        raise_fault(ERR_EMPTY_WORD);
                    end
                    else
                    begin
                        fold_digit(c);
                        add_result(EV_TEXT, KIND_WORD, c, '0, ERR_NONE);
                    end
                end
                LX_STRING:
                begin
                    if (c == CH_QUOTE)
                    begin
                        add_result(EV_TOKEN_END, KIND_STRING, 8'h00, '0, ERR_NONE);
                        lex_state = LX_IDLE;
                    end
                    else if (c >= CH_SPACE && c <= CH_TILDE)
                    begin
                        add_result(EV_TEXT, KIND_WORD, c, '0, ERR_NONE);
                    end
                    else
                    begin
                        raise_fault(ERR_BAD_STRING);
                    end
                end
                default:
                begin
                    if (c == CH_NEWLINE)
                    begin
                        lex_state = LX_IDLE;
                    end
                end
            endcase
        end
        for (int i = 0; i < step_n; i++)
        begin
            step_res[i].fin = (i == step_n - 1);
            token_results.push_back(step_res[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Predict on every source transfer, compare on every result transfer.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        lex_result_t want;
        if (!rst_n)
        begin
            lex_state  = LX_IDLE;
            fault_code = ERR_NONE;
            clear_number();
            token_results.delete();
            pending_results <= 0;
        end
        else
        begin
            if (src_valid && !src_stall)
            begin
                lex_item(mode, in_byte);
            end
            if (res_valid && !res_stall)
            begin
                if (token_results.size() == 0)
                begin
                    $error("unexpected result transfer: event %0d", event_res);
                    mismatches++;
                end
                else
                begin
                    want = token_results.pop_front();
                    check_field("event_res", 64'(want.ev), 64'(event_res));
                    check_field("token_kind", 64'(want.kind), 64'(token_kind));
                    check_field("text_byte", 64'(want.chr), 64'(text_byte));
                    check_field("number_value", 64'(want.value), 64'(number_value));
                    check_field("error_code", 64'(want.err), 64'(error_code));
                    check_field("last", 64'(want.fin), 64'(last));
                end
            end
            pending_results <= token_results.size();
            fail_count      <= mismatches;
        end
    end

endmodule

>>> verif/tb_forth_source_lexer_core.sv
module tb_forth_source_lexer_core;

    import fsl_pkg::*;

    localparam int VALUE_BITS   = 64;
    localparam int STUCK_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_ITEMS  = 150;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  src_valid = 1'b0;
    logic                  src_stall;
    logic                  mode      = MODE_BYTE;
    logic [7:0]            in_byte   = 8'h00;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic [1:0]            event_res;
    logic [1:0]            token_kind;
    logic [7:0]            text_byte;
    logic [VALUE_BITS-1:0] number_value;
    logic [2:0]            error_code;
    logic                  last;

    int   fail_count;
    int   pending_results;
    int   src_idle_pct  = 0;
    int   res_stall_pct = 0;
    int   items_sent    = 0;
    int   stuck_cycles  = 0;
    int   hold_left     = 0;
    logic hold_armed    = 1'b0;
    logic hold_used     = 1'b0;

    forth_source_lexer_core #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .mode(mode),
        .in_byte(in_byte),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .event_res(event_res),
        .token_kind(token_kind),
        .text_byte(text_byte),
        .number_value(number_value),
        .error_code(error_code),
        .last(last)
    );

    forth_source_lexer_checker #(
        .VALUE_BITS(VALUE_BITS)
    ) lexer_checker (
        .clk(clk),
        .rst_n(rst_n),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .mode(mode),
        .in_byte(in_byte),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .event_res(event_res),
        .token_kind(token_kind),
        .text_byte(text_byte),
        .number_value(number_value),
        .error_code(error_code),
        .last(last),
        .fail_count(fail_count),
        .pending_results(pending_results)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stalls, plus one long hold-off once it is armed.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_armed && !hold_used)
        begin
            res_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_used <= 1'b1;
        end
        else
        begin
            res_stall <= ($urandom_range(0, 99) < res_stall_pct);
        end
    end

    // Watchdog: give up when neither channel has moved for too long.
    always @(posedge clk)
    begin
        if ((src_valid && !src_stall) || (res_valid && !res_stall))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Offer one source item, idling first at random, and wait for its transfer.
    task automatic send_item(input logic m, input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        mode      <= m;
        in_byte   <= b;
        @(posedge clk);
        while (src_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            send_item(MODE_BYTE, s[i]);
        end
    endtask

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10)
        begin
            return CH_ZERO + 8'(d);
        end
        if (d < 16)
        begin
            return CH_A_LOWER + 8'(d - 10);
        end
        return CH_F_LOWER + 8'd1;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // One random token followed by up to three separator bytes; never leads to an error.
    task automatic send_token();
        int         pick;
        int         n;
        int         i;
        int         r;
        int         d;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            // Decimal number, sometimes long enough to wrap.
            if ($urandom_range(0, 3) == 0)
            begin
                send_item(MODE_BYTE, CH_MINUS);
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 26) : $urandom_range(1, 5);
            for (i = 0; i < n; i++)
            begin
                send_item(MODE_BYTE, digit_char($urandom_range(0, 9)));
            end
        end
        else if (pick < 50)
        begin
            // Prefixed number, with the odd digit outside the radix.
            if ($urandom_range(0, 3) == 0)
            begin
                send_item(MODE_BYTE, CH_MINUS);
            end
            send_item(MODE_BYTE, CH_ZERO);
            case ($urandom_range(0, 2))
                0: begin c = CH_B_LOWER; r = 2; end
                1: begin c = CH_O_LOWER; r = 8; end
                default: begin c = CH_X_LOWER; r = 16; end
            endcase
            send_item(MODE_BYTE, c);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 66) : $urandom_range(0, 6);
            for (i = 0; i < n; i++)
            begin
                d = ($urandom_range(0, 24) == 0) ? $urandom_range(r, 16) : $urandom_range(0, r - 1);
                send_item(MODE_BYTE, digit_char(d));
            end
        end
        else if (pick < 65)
        begin
            // Plain word of arbitrary bytes.
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
            begin
                do
                begin
                    c = 8'($urandom_range(1, 255));
                end
                while (is_blank(c) || c == CH_QUOTE || c == CH_HASH
                       || (i == 0 && c == CH_BACKSLASH));
                send_item(MODE_BYTE, c);
            end
        end
        else if (pick < 78)
        begin
            // String of printable bytes.
            send_item(MODE_BYTE, CH_QUOTE);
            n = $urandom_range(0, 8);
            for (i = 0; i < n; i++)
            begin
                do
                begin
                    c = 8'($urandom_range(CH_SPACE, CH_TILDE));
                end
                while (c == CH_QUOTE);
                send_item(MODE_BYTE, c);
            end
            send_item(MODE_BYTE, CH_QUOTE);
        end
        else if (pick < 86)
        begin
            // Comment; the leading space makes sure a word in progress ends first.
            send_item(MODE_BYTE, CH_SPACE);
            send_item(MODE_BYTE, CH_BACKSLASH);
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++)
            begin
                do
                begin
                    c = 8'($urandom_range(1, 255));
                end
                while (c == CH_NEWLINE);
                send_item(MODE_BYTE, c);
            end
            send_item(MODE_BYTE, CH_NEWLINE);
        end
        else if (pick < 92)
        begin
            send_item(MODE_EOS, 8'($urandom_range(0, 255)));
        end
        else
        begin
            // Loose bytes that cannot open a string or hit a hash.
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
            begin
                do
                begin
                    c = 8'($urandom_range(1, 255));
                end
                while (c == CH_QUOTE || c == CH_HASH);
                send_item(MODE_BYTE, c);
            end
        end
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++)
        begin
            c = $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
            send_item(MODE_BYTE, c);
        end
    endtask

    // Errors stick until reset, so exactly one kind closes the run.
    task automatic send_fault();
        int         i;
        logic [7:0] c;
        send_item(MODE_EOS, 8'($urandom_range(0, 255)));
        case ($urandom_range(0, 7))
            0: send_item(MODE_BYTE, CH_HASH);
            1:
            begin
                send_text("12");
                send_item(MODE_BYTE, CH_HASH);
            end
            2: send_item(MODE_BYTE, CH_NUL);
            3:
            begin
                send_text("ab");
                send_item(MODE_BYTE, CH_NUL);
            end
            4:
            begin
                send_text("\"x");
                send_item(MODE_BYTE, CH_NUL);
            end
            5:
            begin
                send_text("\\x");
                send_item(MODE_BYTE, CH_NUL);
            end
            6:
            begin
                send_text("\"x");
                do
                begin
                    c = 8'($urandom_range(1, 255));
                end
                while (c >= CH_SPACE && c <= CH_TILDE);
                send_item(MODE_BYTE, c);
            end
            default:
            begin
                send_text("\"x");
                send_item(MODE_EOS, 8'($urandom_range(0, 255)));
            end
        endcase
        for (i = 0; i < 6; i++)
        begin
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int phase;
        int start;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lone minus, prefix only, word ended by quote, string extremes,
        // comment, end of source in a word and in a comment.
        send_item(MODE_BYTE, CH_MINUS);
        send_item(MODE_BYTE, CH_SPACE);
        send_text("0x\"~ \"");
        send_text("\\q\n");
        send_text("-0b1");
        send_item(MODE_EOS, 8'hFF);
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_BYTE, 8'h01);
        send_item(MODE_BYTE, CH_CR);
        send_text("0o17\t");
        send_item(MODE_BYTE, CH_BACKSLASH);
        send_item(MODE_EOS, 8'h00);

        // Random phases with different idling; the first one also holds off
        // the result side long enough to back up the source channel.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 0;
                    res_stall_pct = 0;
                    hold_armed   <= 1'b1;
                end
                1:
                begin
                    src_idle_pct  = 74;
                    res_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    res_stall_pct = 74;
                end
                default:
                begin
                    src_idle_pct  = 33;
                    res_stall_pct = 33;
                end
            endcase
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                send_token();
            end
        end

        send_fault();
        src_valid <= 1'b0;

        // Wait for the checker's count to include the results of the final transfer.
        @(posedge clk);
        while (pending_results != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> forth_source_lexer_core.f
+incdir+sv
sv/fsl_pkg.sv
sv/fsl_front.sv
sv/fsl_queue.sv
sv/fsl_back.sv
sv/forth_source_lexer_core.sv
sv/fsl_checker.sv
verif/forth_source_lexer_checker.sv
verif/tb_forth_source_lexer_core.sv
